>>> hdl/assert_macros.svh
// assertion macros shared by the escape decoder rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define BSED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen outside reset
`define BSED_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> hdl/bsed_pkg.sv
// types and constants for the backslash escape decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsed_pkg;

	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_ESC  = 2'd1,
		PH_OCT  = 2'd2,
		PH_STOP = 2'd3
	} phase_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_C      = 8'h63;

	// one queue entry: up to two results of one input byte
	typedef struct packed {
		logic [7:0] first_val;
		logic       first_has;
		logic       first_stop;
		logic       two;
		logic [7:0] second_val;
	} entry_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} esc_t;

	// single-byte escapes
	function automatic esc_t esc_lookup(input logic [7:0] b);
		esc_t r;
		r.hit = 1'b1;
		unique case (b)
			8'h61:     r.code = 8'h07; // a
			8'h62:     r.code = 8'h08; // b
			8'h66:     r.code = 8'h0C; // f
			8'h6E:     r.code = 8'h0A; // n
			8'h72:     r.code = 8'h0D; // r
			8'h74:     r.code = 8'h09; // t
			8'h76:     r.code = 8'h0B; // v
			CH_BSLASH: r.code = CH_BSLASH;
			CH_NUL:    r.code = CH_BSLASH; // trailing backslash
			default: begin
				r.hit  = 1'b0;
				r.code = CH_NUL;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/backslash_escape_decoder.sv
// backslash escape decoder, top level
// depends on bsed_pkg, bsed_front, bsed_fifo, bsed_back
`timescale 1ns / 1ps
`default_nettype none

// usage:
//   input queue: drive in_byte and push; a byte is taken at an edge with push high
//   and full low. a byte of zero ends a string.
//   result queue: while empty is low the oldest item sits on out_byte, has_byte,
//   stop_seen and last; it is taken at an edge with pop high.
//   config: cfg_wr_en with cfg_wr_data writes argument_mode; write it only while idle.
//   one byte is accepted per cycle while full is low. a byte gives zero, one or
//   two items; its first item passes the queue, then the output register, and a
//   second one follows it. the output register drains one item per cycle while
//   pop is high, so bytes that give two items run at half rate once the queue
//   between front and back end has filled. if the receiver stalls, the queue
//   (QUEUE_DEPTH entries) fills and full rises; nothing is lost.
//   reset: plain text phase, argument_mode 0, queue and output register empty.

module backslash_escape_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic            stop_seen,
	output logic            last
);
	import bsed_pkg::*;

	logic   q_push, q_full, q_nonempty, q_pop;
	entry_t q_wdata, q_rdata;

	assign full = q_full;

	bsed_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.in_byte     (in_byte),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	bsed_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.nonempty (q_nonempty),
		.pop      (q_pop),
		.rdata    (q_rdata)
	);

	bsed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.stop_seen  (stop_seen),
		.last       (last)
	);

endmodule

`default_nettype wire

>>> hdl/bsed_front.sv
// front end: accepts text bytes, tracks escape state, turns each byte into
// at most one queue entry; depends on bsed_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsed_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic            cfg_wr_data,
	input  wire logic            push,
	input  wire logic [7:0]      in_byte,
	input  wire logic            q_full,
	output logic                 q_push,
	output bsed_pkg::entry_t     q_data
);
	import bsed_pkg::*;

	logic        arg_mode_q;
	phase_t      phase_q, phase_d;
	logic [8:0]  octal_q, octal_d;
	logic [1:0]  digits_q, digits_d;
	logic        accept;
	logic        is_oct;
	logic        emit;
	esc_t        esc;

	assign accept = push && !q_full;
	assign is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
	assign esc    = esc_lookup(in_byte);

	// next state
	always_comb begin
		phase_d  = phase_q;
		octal_d  = octal_q;
		digits_d = digits_q;
		unique case (phase_q)
			PH_TEXT: begin
				if (in_byte == CH_BSLASH) phase_d = PH_ESC;
			end
			PH_ESC: begin
				phase_d = PH_TEXT;
				if (!esc.hit && in_byte == CH_C) begin
					if (arg_mode_q) phase_d = PH_STOP;
				end else if (!esc.hit && is_oct) begin
					phase_d = PH_OCT;
					if (arg_mode_q && in_byte == CH_ZERO) begin
						octal_d  = '0;
						digits_d = 2'd3;
					end else begin
						octal_d  = {6'd0, in_byte[2:0]};
						digits_d = 2'd2;
					end
				end
			end
			PH_OCT: begin
				if (is_oct && digits_q != 2'd0) begin
					octal_d  = {octal_q[5:0], in_byte[2:0]};
					digits_d = digits_q - 2'd1;
					if (digits_q == 2'd1) phase_d = PH_TEXT;
				end else begin
					digits_d = 2'd0;
					phase_d  = (in_byte == CH_BSLASH) ? PH_ESC : PH_TEXT;
				end
			end
			PH_STOP: begin
				if (in_byte == CH_NUL) phase_d = PH_TEXT;
			end
		endcase
	end

	// outputs
	always_comb begin
		emit   = 1'b0;
		q_data = '0;
		unique case (phase_q)
			PH_TEXT: begin
				if (in_byte != CH_NUL && in_byte != CH_BSLASH) begin
					emit             = 1'b1;
					q_data.first_val = in_byte;
					q_data.first_has = 1'b1;
				end
			end
			PH_ESC: begin
				if (esc.hit) begin
					emit             = 1'b1;
					q_data.first_val = esc.code;
					q_data.first_has = 1'b1;
				end else if (in_byte == CH_C && arg_mode_q) begin
					emit              = 1'b1;
					q_data.first_stop = 1'b1;
				end else if (in_byte == CH_C || !is_oct) begin
					emit              = 1'b1;
					q_data.first_val  = CH_BSLASH;
					q_data.first_has  = 1'b1;
					q_data.two        = 1'b1;
					q_data.second_val = in_byte;
				end
			end
			PH_OCT: begin
				if (is_oct && digits_q != 2'd0) begin
					if (digits_q == 2'd1) begin
						emit             = 1'b1;
						q_data.first_val = {octal_q[4:0], in_byte[2:0]};
						q_data.first_has = 1'b1;
					end
				end else begin
					emit              = 1'b1;
					q_data.first_val  = octal_q[7:0];
					q_data.first_has  = 1'b1;
					q_data.two        = (in_byte != CH_NUL) && (in_byte != CH_BSLASH);
					q_data.second_val = in_byte;
				end
			end
			PH_STOP: begin
				emit = 1'b0;
			end
		endcase
	end

	assign q_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_mode_q <= 1'b0;
			phase_q    <= PH_TEXT;
			octal_q    <= '0;
			digits_q   <= '0;
		end else begin
			if (cfg_wr_en) arg_mode_q <= cfg_wr_data;
			if (accept) begin
				phase_q  <= phase_d;
				octal_q  <= octal_d;
				digits_q <= digits_d;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/bsed_fifo.sv
// short queue of classified entries between front and back end
// depends on bsed_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsed_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire bsed_pkg::entry_t wdata,
	output logic                  full,
	output logic                  nonempty,
	input  wire logic             pop,
	output bsed_pkg::entry_t      rdata
);
	import bsed_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`BSED_ASSERT(a_count_range, count_q <= CW'(DEPTH), "queue count above depth")
	`BSED_ASSERT(a_ptr_count, (wr_ptr_q == rd_ptr_q) |-> (count_q == '0 || full), "pointers and count disagree")

endmodule

`default_nettype wire

>>> hdl/bsed_back.sv
// back end: expands queue entries into single results in an output register
// depends on bsed_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsed_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_nonempty,
	input  wire bsed_pkg::entry_t q_data,
	output logic                  q_pop,
	output logic                  empty,
	input  wire logic             pop,
	output logic [7:0]            out_byte,
	output logic                  has_byte,
	output logic                  stop_seen,
	output logic                  last
);
	import bsed_pkg::*;

	logic       out_valid_q;
	logic       sec_valid_q;
	logic [7:0] sec_byte_q;
	logic [7:0] out_byte_q;
	logic       has_byte_q, stop_seen_q, last_q;
	logic       slot_free, load_sec, load_head;

	assign slot_free = !out_valid_q || pop;
	assign load_sec  = slot_free && sec_valid_q;
	assign load_head = slot_free && !sec_valid_q && q_nonempty;
	assign q_pop     = load_head;

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign has_byte  = has_byte_q;
	assign stop_seen = stop_seen_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= sec_valid_q || q_nonempty;
			sec_valid_q <= !sec_valid_q && q_nonempty && q_data.two;
		end
	end

	always_ff @(posedge clk) begin
		if (load_sec) begin
			out_byte_q  <= sec_byte_q;
			has_byte_q  <= 1'b1;
			stop_seen_q <= 1'b0;
			last_q      <= 1'b1;
		end else if (load_head) begin
			out_byte_q  <= q_data.first_val;
			has_byte_q  <= q_data.first_has;
			stop_seen_q <= q_data.first_stop;
			last_q      <= !q_data.two;
			sec_byte_q  <= q_data.second_val;
		end
	end

	`BSED_ASSERT(a_sec_behind_out, sec_valid_q |-> out_valid_q, "second item pending with no first")
	`BSED_ASSERT(a_stop_shape, (out_valid_q && stop_seen_q) |-> (!has_byte_q && last_q), "stop item carries a byte")

endmodule

`default_nettype wire

>>> tb/backslash_escape_decoder_tb.sv
// testbench for backslash_escape_decoder: directed and random text streams in both modes
// predicts the decoded items with its own model and checks every item the block pops
// depends on bsed_pkg and backslash_escape_decoder
`timescale 1ns / 1ps

module backslash_escape_decoder_tb;
	import bsed_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 10;
	localparam int SEGMENT_BYTES = 92;

	typedef struct packed {
		logic [7:0] val;
		logic       has;
		logic       stop;
		logic       fin;
	} decoded_t;

	class decode_scoreboard;
		bit         arg_mode;
		phase_t     phase;
		logic [8:0] oct_val;
		logic [1:0] digits_left;
		decoded_t   decoded_q[$];
		int         errors;

		function new();
			arg_mode = 1'b0;
			phase = PH_TEXT;
			oct_val = '0;
			digits_left = '0;
			errors = 0;
		endfunction

		function void set_mode(bit m);
			arg_mode = m;
		endfunction

		function int pending();
			return decoded_q.size();
		endfunction

		function void emit(logic [7:0] v, logic h, logic s);
			decoded_t d;
			d.val = v;
			d.has = h;
			d.stop = s;
			d.fin = 1'b0;
			decoded_q.push_back(d);
		endfunction

		function void plain_text(logic [7:0] b);
			if (b == CH_NUL)
				phase = PH_TEXT;
			else if (b == CH_BSLASH)
				phase = PH_ESC;
			else
				emit(b, 1'b1, 1'b0);
		endfunction

		function void decode_byte(logic [7:0] b);
			int       n0;
			decoded_t d;
			n0 = decoded_q.size();
			case (phase)
				PH_TEXT: plain_text(b);
				PH_ESC: begin
					phase = PH_TEXT;
					case (b)
						"a": emit(8'h07, 1'b1, 1'b0);
						"b": emit(8'h08, 1'b1, 1'b0);
						"f": emit(8'h0C, 1'b1, 1'b0);
						"n": emit(8'h0A, 1'b1, 1'b0);
						"r": emit(8'h0D, 1'b1, 1'b0);
						"t": emit(8'h09, 1'b1, 1'b0);
						"v": emit(8'h0B, 1'b1, 1'b0);
						CH_BSLASH, CH_NUL: emit(CH_BSLASH, 1'b1, 1'b0);
						CH_C: begin
							if (arg_mode) begin
								phase = PH_STOP;
								emit(8'h00, 1'b0, 1'b1);
							end else begin
								emit(CH_BSLASH, 1'b1, 1'b0);
								emit(b, 1'b1, 1'b0);
							end
						end
						default: begin
							if (b >= CH_ZERO && b <= CH_SEVEN) begin
								if (arg_mode && b == CH_ZERO) begin
									oct_val = '0;
									digits_left = 2'd3;
								end else begin
									oct_val = {6'd0, b[2:0]};
									digits_left = 2'd2;
								end
								phase = PH_OCT;
							end else begin
								emit(CH_BSLASH, 1'b1, 1'b0);
								emit(b, 1'b1, 1'b0);
							end
						end
					endcase
				end
				PH_OCT: begin
					if (b >= CH_ZERO && b <= CH_SEVEN && digits_left != 2'd0) begin
						oct_val = {oct_val[5:0], b[2:0]};
						digits_left = digits_left - 2'd1;
						if (digits_left == 2'd0) begin
							phase = PH_TEXT;
							emit(oct_val[7:0], 1'b1, 1'b0);
						end
					end else begin
						phase = PH_TEXT;
						digits_left = '0;
						emit(oct_val[7:0], 1'b1, 1'b0);
						plain_text(b);
					end
				end
				default: begin
					if (b == CH_NUL)
						phase = PH_TEXT;
				end
			endcase
			if (decoded_q.size() > n0) begin
				d = decoded_q.pop_back();
				d.fin = 1'b1;
				decoded_q.push_back(d);
			end
		endfunction

		function void check(logic [7:0] v, logic h, logic s, logic f);
			decoded_t d;
			if (decoded_q.size() == 0) begin
				$error("unexpected item: out_byte %h has_byte %b stop_seen %b last %b",
					v, h, s, f);
				errors++;
				return;
			end
			d = decoded_q.pop_front();
			if (v !== d.val) begin
				$error("out_byte: expected %h, got %h", d.val, v);
				errors++;
			end
			if (h !== d.has) begin
				$error("has_byte: expected %b, got %b", d.has, h);
				errors++;
			end
			if (s !== d.stop) begin
				$error("stop_seen: expected %b, got %b", d.stop, s);
				errors++;
			end
			if (f !== d.fin) begin
				$error("last: expected %b, got %b", d.fin, f);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic       cfg_wr_data;
	logic       push;
	logic       full;
	logic [7:0] in_byte;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       stop_seen;
	logic       last;

	decode_scoreboard sb;
	int         snd_idle_pct;
	int         rcv_idle_pct;
	bit         hold_go;
	int         idle_cycles;
	logic [7:0] text_q[$];

	backslash_escape_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.stop_seen  (stop_seen),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < snd_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (full);
		sb.decode_byte(b);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_mode(m);
	endtask

	task automatic send_text();
		while (text_q.size() != 0)
			send_byte(text_q.pop_front());
	endtask

	// one random chunk of text: mostly escapes, some plain bytes and string ends
	task automatic queue_random_text();
		int pick;
		int k;
		pick = $urandom_range(99);
		if (pick < 35) begin
			text_q.push_back(8'($urandom_range(255)));
		end else if (pick < 43) begin
			text_q.push_back(CH_NUL);
		end else if (pick < 65) begin
			text_q.push_back(CH_BSLASH);
			case ($urandom_range(9))
				0: text_q.push_back("a");
				1: text_q.push_back("b");
				2: text_q.push_back("f");
				3: text_q.push_back("n");
				4: text_q.push_back("r");
				5: text_q.push_back("t");
				6: text_q.push_back("v");
				7: text_q.push_back(CH_BSLASH);
				8: text_q.push_back(CH_C);
				default: text_q.push_back(CH_NUL);
			endcase
		end else if (pick < 88) begin
			text_q.push_back(CH_BSLASH);
			if ($urandom_range(1))
				text_q.push_back(CH_ZERO);
			else
				text_q.push_back(CH_ZERO + 8'($urandom_range(7)));
			k = $urandom_range(4);
			repeat (k) text_q.push_back(CH_ZERO + 8'($urandom_range(7)));
			if ($urandom_range(1))
				text_q.push_back(8'($urandom_range(255)));
		end else begin
			text_q.push_back(CH_BSLASH);
			text_q.push_back(8'($urandom_range(1, 255)));
		end
	endtask

	// receiver
	initial begin
		int hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= rcv_idle_pct);
			end
			@(posedge clk);
			if (pop && !empty)
				sb.check(out_byte, has_byte, stop_seen, last);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL backslash_escape_decoder");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		push = 1'b0;
		in_byte = 8'h00;
		pop = 1'b0;
		hold_go = 1'b0;
		idle_cycles = 0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		sb = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// format rules
		write_mode(1'b0);
		text_q = '{"A", 8'hFF, CH_BSLASH, "n", CH_BSLASH, CH_C, CH_BSLASH, "q",
			CH_BSLASH, "7", "7", "7", CH_BSLASH, "5", CH_NUL, CH_BSLASH, CH_NUL,
			CH_NUL, CH_BSLASH};
		send_text();
		// mode switched while an escape is open
		write_mode(1'b1);
		text_q = '{CH_C, "z", CH_NUL, CH_BSLASH, CH_ZERO, "1", "2", "3"};
		send_text();

		for (int seg = 0; seg < 6; seg++) begin
			int sent;
			write_mode(seg % 2 == 0 ? 1'b0 : 1'b1);
			snd_idle_pct = seg < 2 ? 24 : (seg < 4 ? 73 : 0);
			rcv_idle_pct = seg < 2 ? 73 : (seg < 4 ? 24 : 0);
			if (seg == 0 || seg == 4)
				hold_go = 1'b1;
			sent = 0;
			while (sent < SEGMENT_BYTES) begin
				queue_random_text();
				sent += text_q.size();
				send_text();
			end
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS backslash_escape_decoder");
		else
			$display("FAIL backslash_escape_decoder");
		$finish;
	end

endmodule
